// ===== rtl/core/pfba_pkg.sv =====
package pfba_pkg;

  localparam int MAX_FRAMES = 65536;
  localparam int FRAME_W    = 17;
  localparam int WORD_BITS  = 64;
  localparam int MAP_WORDS  = MAX_FRAMES / WORD_BITS;
  localparam int MAP_AW     = $clog2(MAP_WORDS);
  localparam int BIT_AW     = $clog2(WORD_BITS);
  localparam int ADDR_W     = 40;
  localparam int PAGE_SHIFT = 12;

  typedef logic [FRAME_W-1:0] frame_t;

  // operation codes
  localparam logic [2:0] OP_CLEAR     = 3'd0;
  localparam logic [2:0] OP_MARK      = 3'd1;
  localparam logic [2:0] OP_ALLOC_LO  = 3'd2;
  localparam logic [2:0] OP_ALLOC_HI  = 3'd3;
  localparam logic [2:0] OP_ALLOC_RUN = 3'd4;
  localparam logic [2:0] OP_FREE      = 3'd5;
  localparam logic [2:0] OP_FREE_RUN  = 3'd6;
  localparam logic [2:0] OP_RESERVED  = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  // register indexes
  localparam logic [1:0] REG_N_FRAMES    = 2'd0;
  localparam logic [1:0] REG_FIRST_ALLOC = 2'd1;
  localparam logic [1:0] REG_HOLE_FIRST  = 2'd2;
  localparam logic [1:0] REG_HOLE_END    = 2'd3;

  localparam frame_t HOLE_FIRST_RST = frame_t'(1024);
  localparam frame_t HOLE_END_RST   = frame_t'(1536);

endpackage

// ===== rtl/core/pfba_ram.sv =====
module pfba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/page_frame_bitmap_allocator_top.sv =====
// channel   direction  handshake                   payload
// in        input      in_valid / in_stall         op, region fields, address, page_count
// out       output     out_valid / out_stall       status, frame_address
// config    input      psel/penable/pwrite/pready  four 17-bit registers at 0x0..0xc
//
// one item takes a few cycles plus one cycle per frame visited by the walker
// (a run allocation visits the found run a second time to clear it),
// plus three cycles each time the walk moves to another 64-frame map word,
// four when the cached word must be written back first
// clear takes 1024 cycles, one map word per cycle
// after reset the same 1024-cycle clearing pass runs; in_stall stays high meanwhile
// the result sits in an output register, so out_stall only holds the next result back

module page_frame_bitmap_allocator_top
  import pfba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_op,
  input  logic [39:0]       in_region_base,
  input  logic [39:0]       in_region_length,
  input  logic              in_region_usable,
  input  logic [39:0]       in_address,
  input  logic [16:0]       in_page_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [39:0]       out_frame_address,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_STEP  = 4'd3;
  localparam logic [3:0] S_FLUSH = 4'd4;
  localparam logic [3:0] S_FETCH = 4'd5;
  localparam logic [3:0] S_LOAD  = 4'd6;
  localparam logic [3:0] S_END   = 4'd7;

  // configuration registers
  frame_t cfg_n_frames_r, cfg_first_r, cfg_hole_first_r, cfg_hole_end_r;
  logic   cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_n_frames_r    <= '0;
      cfg_first_r       <= '0;
      cfg_hole_first_r  <= HOLE_FIRST_RST;
      cfg_hole_end_r    <= HOLE_END_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_N_FRAMES:    cfg_n_frames_r    <= pwdata[FRAME_W-1:0];
        REG_FIRST_ALLOC: cfg_first_r       <= pwdata[FRAME_W-1:0];
        REG_HOLE_FIRST:  cfg_hole_first_r  <= pwdata[FRAME_W-1:0];
        REG_HOLE_END:    cfg_hole_end_r    <= pwdata[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_N_FRAMES:    prdata[FRAME_W-1:0] = cfg_n_frames_r;
      REG_FIRST_ALLOC: prdata[FRAME_W-1:0] = cfg_first_r;
      REG_HOLE_FIRST:  prdata[FRAME_W-1:0] = cfg_hole_first_r;
      REG_HOLE_END:    prdata[FRAME_W-1:0] = cfg_hole_end_r;
      default: ;
    endcase
  end

  // effective frame count, clipped to the map size
  frame_t n_eff;
  assign n_eff = (cfg_n_frames_r > frame_t'(MAX_FRAMES)) ? frame_t'(MAX_FRAMES)
                                                        : cfg_n_frames_r;

  // sequencer state
  logic [3:0]          state_r, state_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [39:0]         base_r, base_nxt, len_r, len_nxt, addr_r, addr_nxt;
  logic                use_r, use_nxt;
  frame_t              cnt_r, cnt_nxt;
  frame_t              cur_r, cur_nxt;   // frame being visited
  frame_t              aux_r, aux_nxt;   // upper bound, run end or frames left
  frame_t              stt_r, stt_nxt;   // run start
  frame_t              run_r, run_nxt;
  logic                ph_r, ph_nxt;     // run alloc: clearing pass
  logic [1:0]          res_st_r, res_st_nxt;
  frame_t              res_fr_r, res_fr_nxt;
  logic [MAP_AW-1:0]   clr_idx_r, clr_idx_nxt;
  logic                clr_op_r, clr_op_nxt;

  // one-word cache in front of the map memory
  logic [WORD_BITS-1:0] wbuf_r, wbuf_nxt;
  logic [MAP_AW-1:0]    widx_r, widx_nxt;
  logic                 wvalid_r, wvalid_nxt, wdirty_r, wdirty_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [39:0]          out_addr_r, out_addr_nxt;

  // map memory port
  logic                 ram_we;
  logic [MAP_AW-1:0]    ram_addr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  pfba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // setup arithmetic for mark region and frees
  logic [40:0] lo_sum, hi_sum;
  logic [28:0] lo_pg, hi_pg, lo_c, hi_c;
  logic [27:0] fr_pg;
  logic        misal, fr_oor;

  assign lo_sum = {1'b0, base_r} + 41'd4095;
  assign hi_sum = {1'b0, base_r} + {1'b0, len_r};
  assign lo_pg  = lo_sum[40:PAGE_SHIFT];
  assign hi_pg  = hi_sum[40:PAGE_SHIFT];
  assign lo_c   = (lo_pg < {12'b0, cfg_first_r}) ? {12'b0, cfg_first_r} : lo_pg;
  assign hi_c   = (hi_pg > {12'b0, n_eff}) ? {12'b0, n_eff} : hi_pg;
  assign fr_pg  = addr_r[39:PAGE_SHIFT];
  assign misal  = |addr_r[PAGE_SHIFT-1:0];
  assign fr_oor = ({11'b0, n_eff} <= fr_pg);

  // per-frame view of the cached word
  logic   word_hit, cur_bit, cur_hole, cur_use;
  frame_t cur_p1, run_p1;

  assign word_hit = wvalid_r && (widx_r == cur_r[FRAME_W-2:BIT_AW]);
  assign cur_bit  = wbuf_r[cur_r[BIT_AW-1:0]];
  assign cur_hole = (cur_r >= cfg_hole_first_r) && (cur_r < cfg_hole_end_r);
  assign cur_use  = cur_bit && !cur_hole;
  assign cur_p1   = cur_r + frame_t'(1);
  assign run_p1   = cur_use ? (run_r + frame_t'(1)) : '0;

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    base_nxt       = base_r;
    len_nxt        = len_r;
    addr_nxt       = addr_r;
    use_nxt        = use_r;
    cnt_nxt        = cnt_r;
    cur_nxt        = cur_r;
    aux_nxt        = aux_r;
    stt_nxt        = stt_r;
    run_nxt        = run_r;
    ph_nxt         = ph_r;
    res_st_nxt     = res_st_r;
    res_fr_nxt     = res_fr_r;
    clr_idx_nxt    = clr_idx_r;
    clr_op_nxt     = clr_op_r;
    wbuf_nxt       = wbuf_r;
    widx_nxt       = widx_r;
    wvalid_nxt     = wvalid_r;
    wdirty_nxt     = wdirty_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    ram_we         = 1'b0;
    ram_addr       = cur_r[FRAME_W-2:BIT_AW];
    ram_wdata      = wbuf_r;

    unique case (state_r)
      S_CLR: begin
        // one map word zeroed per cycle
        ram_we      = 1'b1;
        ram_addr    = clr_idx_r;
        ram_wdata   = '0;
        clr_idx_nxt = clr_idx_r + MAP_AW'(1);
        wvalid_nxt  = 1'b0;
        wdirty_nxt  = 1'b0;
        if (clr_idx_r == MAP_AW'(MAP_WORDS - 1)) begin
          if (clr_op_r) begin
            res_st_nxt = ST_OK;
            res_fr_nxt = '0;
            state_nxt  = S_END;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          base_nxt  = in_region_base;
          len_nxt   = in_region_length;
          use_nxt   = in_region_usable;
          addr_nxt  = in_address;
          cnt_nxt   = in_page_count;
          state_nxt = S_SETUP;
        end
      end

      S_SETUP: begin
        res_st_nxt = ST_OK;
        res_fr_nxt = '0;
        run_nxt    = '0;
        ph_nxt     = 1'b0;
        state_nxt  = S_STEP;
        unique case (op_r)
          OP_CLEAR: begin
            clr_idx_nxt = '0;
            clr_op_nxt  = 1'b1;
            state_nxt   = S_CLR;
          end
          OP_MARK: begin
            cur_nxt = lo_c[FRAME_W-1:0];
            aux_nxt = hi_c[FRAME_W-1:0];
            if (!use_r || lo_c >= hi_c) begin
              state_nxt = S_END;
            end
          end
          OP_ALLOC_LO: begin
            cur_nxt = cfg_first_r;
            if (cfg_first_r >= n_eff) begin
              res_st_nxt = ST_NO_SPACE;
              state_nxt  = S_END;
            end
          end
          OP_ALLOC_HI: begin
            cur_nxt = n_eff - frame_t'(1);
            if (n_eff <= cfg_first_r) begin
              res_st_nxt = ST_NO_SPACE;
              state_nxt  = S_END;
            end
          end
          OP_ALLOC_RUN: begin
            cur_nxt = cfg_first_r;
            if (cnt_r == '0 || cfg_first_r >= n_eff) begin
              res_st_nxt = ST_NO_SPACE;
              state_nxt  = S_END;
            end
          end
          OP_FREE: begin
            cur_nxt = fr_pg[FRAME_W-1:0];
            priority if (addr_r == '0) begin
              state_nxt = S_END;
            end else if (misal || fr_oor) begin
              res_st_nxt = ST_BAD_FREE;
              state_nxt  = S_END;
            end else begin
              state_nxt = S_STEP;
            end
          end
          OP_FREE_RUN: begin
            cur_nxt = fr_pg[FRAME_W-1:0];
            aux_nxt = cnt_r;
            priority if (addr_r == '0 || cnt_r == '0) begin
              state_nxt = S_END;
            end else if (misal || fr_oor) begin
              res_st_nxt = ST_BAD_FREE;
              state_nxt  = S_END;
            end else begin
              state_nxt = S_STEP;
            end
          end
          default: state_nxt = S_END;
        endcase
      end

      S_STEP: begin
        if (!word_hit) begin
          state_nxt = wdirty_r ? S_FLUSH : S_FETCH;
        end else begin
          unique case (op_r)
            OP_MARK: begin
              wbuf_nxt[cur_r[BIT_AW-1:0]] = 1'b1;
              wdirty_nxt = 1'b1;
              cur_nxt    = cur_p1;
              if (cur_p1 == aux_r) begin
                state_nxt = S_END;
              end
            end
            OP_ALLOC_LO: begin
              priority if (cur_use) begin
                wbuf_nxt[cur_r[BIT_AW-1:0]] = 1'b0;
                wdirty_nxt = 1'b1;
                res_fr_nxt = cur_r;
                state_nxt  = S_END;
              end else if (cur_p1 == n_eff) begin
                res_st_nxt = ST_NO_SPACE;
                state_nxt  = S_END;
              end else begin
                cur_nxt = cur_p1;
              end
            end
            OP_ALLOC_HI: begin
              priority if (cur_use) begin
                wbuf_nxt[cur_r[BIT_AW-1:0]] = 1'b0;
                wdirty_nxt = 1'b1;
                res_fr_nxt = cur_r;
                state_nxt  = S_END;
              end else if (cur_r == cfg_first_r) begin
                res_st_nxt = ST_NO_SPACE;
                state_nxt  = S_END;
              end else begin
                cur_nxt = cur_r - frame_t'(1);
              end
            end
            OP_ALLOC_RUN: begin
              if (ph_r) begin
                // second pass clears the run that was found
                wbuf_nxt[cur_r[BIT_AW-1:0]] = 1'b0;
                wdirty_nxt = 1'b1;
                cur_nxt    = cur_p1;
                if (cur_r == aux_r) begin
                  res_fr_nxt = stt_r;
                  state_nxt  = S_END;
                end
              end else begin
                run_nxt = run_p1;
                priority if (run_p1 == cnt_r) begin
                  stt_nxt = cur_p1 - cnt_r;
                  cur_nxt = cur_p1 - cnt_r;
                  aux_nxt = cur_r;
                  ph_nxt  = 1'b1;
                end else if (cur_p1 == n_eff) begin
                  res_st_nxt = ST_NO_SPACE;
                  state_nxt  = S_END;
                end else begin
                  cur_nxt = cur_p1;
                end
              end
            end
            OP_FREE: begin
              if (cur_bit) begin
                res_st_nxt = ST_BAD_FREE;
              end else begin
                wbuf_nxt[cur_r[BIT_AW-1:0]] = 1'b1;
                wdirty_nxt = 1'b1;
              end
              state_nxt = S_END;
            end
            OP_FREE_RUN: begin
              priority if (cur_bit) begin
                res_st_nxt = ST_BAD_FREE;
                state_nxt  = S_END;
              end else begin
                wbuf_nxt[cur_r[BIT_AW-1:0]] = 1'b1;
                wdirty_nxt = 1'b1;
                aux_nxt    = aux_r - frame_t'(1);
                cur_nxt    = cur_p1;
                if (aux_r == frame_t'(1)) begin
                  state_nxt = S_END;
                end else if (cur_p1 >= n_eff) begin
                  // next frame of the run is past the managed range
                  res_st_nxt = ST_BAD_FREE;
                  state_nxt  = S_END;
                end
              end
            end
            default: state_nxt = S_END;
          endcase
        end
      end

      S_FLUSH: begin
        ram_we     = 1'b1;
        ram_addr   = widx_r;
        wdirty_nxt = 1'b0;
        state_nxt  = S_FETCH;
      end

      S_FETCH: begin
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        wbuf_nxt   = ram_rdata;
        widx_nxt   = cur_r[FRAME_W-2:BIT_AW];
        wvalid_nxt = 1'b1;
        state_nxt  = S_STEP;
      end

      S_END: begin
        ram_we     = wdirty_r;
        ram_addr   = widx_r;
        wdirty_nxt = 1'b0;
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_st_r;
          out_addr_nxt   = {11'b0, res_fr_r, 12'b0};
          wvalid_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      clr_op_r    <= 1'b0;
      wvalid_r    <= 1'b0;
      wdirty_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_op_r    <= clr_op_nxt;
      wvalid_r    <= wvalid_nxt;
      wdirty_r    <= wdirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    base_r       <= base_nxt;
    len_r        <= len_nxt;
    addr_r       <= addr_nxt;
    use_r        <= use_nxt;
    cnt_r        <= cnt_nxt;
    cur_r        <= cur_nxt;
    aux_r        <= aux_nxt;
    stt_r        <= stt_nxt;
    run_r        <= run_nxt;
    ph_r         <= ph_nxt;
    res_st_r     <= res_st_nxt;
    res_fr_r     <= res_fr_nxt;
    wbuf_r       <= wbuf_nxt;
    widx_r       <= widx_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_frame_address = out_addr_r;

  // an accepted item always blocks the next one
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // a modified cached word always belongs to a loaded word
  a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wdirty_r |-> wvalid_r)
    else $error("dirty cache word without valid");

  // the map is never written while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !ram_we)
    else $error("map write while idle");

  // a result appears only when leaving the end state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_END)
    else $error("result without finished item");

endmodule
